// File: sv/mtsd_pkg.sv
// Shared types and constants of the Morse text stream decoder.
package mtsd_pkg;

    // Longest code (in symbols) that still walks the tree
    localparam int MAX_CODE_LEN = 7;
    // Ceiling for the pending word-space counter
    localparam int MAX_PENDING = 15;

    // Position at or above which a further step runs off the tree
    localparam int POS_LIMIT = ((1 << MAX_CODE_LEN) < 128) ? (1 << MAX_CODE_LEN) : 128;
    localparam int PENDING_CAP = (MAX_PENDING < 15) ? MAX_PENDING : 15;

    // Tree table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int TABLE_WIDTH = 8;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Character codes
    localparam logic [7:0] SYM_DOT   = 8'h2E;
    localparam logic [7:0] SYM_DASH  = 8'h2D;
    localparam logic [7:0] SYM_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB  = 8'h09;
    localparam logic [7:0] CHAR_CR   = 8'h0D;

    // Spaces in a row that close a word
    localparam logic [2:0] WORD_SPACES = 3'd6;

    // Request kinds
    typedef enum logic [0:0] {
        CMD_DECODE = 1'b0,
        CMD_WRITE  = 1'b1
    } cmd_kind_t;

    // Command handed from the front to the back
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] addr;      // tree position to look up, or table entry to write
        logic [7:0] wdata;     // table value for a write
        logic       finish;    // a letter ends here
        logic       broken;    // that letter ran off the tree
        logic       add_pend;  // a non-empty word closed: one more pending space
        logic       eom;       // end of message: flush pending spaces
    } cmd_t;

endpackage

// File: sv/morse_text_stream_decoder_core.sv
// A request's first result goes through the queue, the execute stage and the output register.
// Throughput: one request per cycle while the queue is not full; results leave one per cycle
//   while out_ready is high; a four-entry queue absorbs the gap as results hold the back end.
// Table writes and lookups share one RAM port in request order, so a letter sees prior writes.
// Reset: tree table reads as empty (per-entry valid bits cleared at once), walk at the root,
//   all counters zero; no clearing pass, requests are taken from the first cycle after reset.
module morse_text_stream_decoder_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       req_type,
    input  logic [7:0] char_in,
    input  logic       end_of_message,
    input  logic [7:0] table_index,
    input  logic [7:0] table_value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       out_last
);

    mtsd_pkg::cmd_t push_cmd;
    mtsd_pkg::cmd_t head_cmd;
    logic           cmd_push;
    logic           q_full;
    logic           head_valid;
    logic           cmd_pop;

    // Front: classify characters, walk the tree position
    mtsd_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .char_in        (char_in),
        .end_of_message (end_of_message),
        .table_index    (table_index),
        .table_value    (table_value),
        .q_full         (q_full),
        .cmd_push       (cmd_push),
        .cmd            (push_cmd)
    );

    // Command queue
    mtsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_data  (push_cmd),
        .full       (q_full),
        .pop        (cmd_pop),
        .head_valid (head_valid),
        .head       (head_cmd)
    );

    // Back: table lookup and result sequencing
    mtsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (head_valid),
        .cmd       (head_cmd),
        .cmd_pop   (cmd_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .out_last  (out_last)
    );

endmodule

// File: sv/mtsd_ram.sv
// Generic single-port RAM with registered read.
module mtsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/mtsd_front.sv
// Front end: accepts requests, tracks letter/word state, issues commands.
module mtsd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic [7:0]         char_in,
    input  logic               end_of_message,
    input  logic [7:0]         table_index,
    input  logic [7:0]         table_value,
    input  logic               q_full,
    output logic               cmd_push,
    output mtsd_pkg::cmd_t     cmd
);

    logic       in_letter_reg, in_letter_next;
    logic       broken_reg, broken_next;
    logic [7:0] pos_reg, pos_next;
    logic [2:0] run_reg, run_next;
    logic       whl_reg, whl_next;

    logic       accept;
    logic       is_write;
    logic       is_space;
    logic       is_ws;
    logic       is_dot;
    logic       is_dash;
    logic       finish;
    logic       add_pend;
    logic [7:0] fin_pos;
    logic       fin_broken;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign is_write = (mtsd_pkg::cmd_kind_t'(req_type) == mtsd_pkg::CMD_WRITE);
    assign is_space = (char_in == mtsd_pkg::SYM_SPACE);
    assign is_ws    = is_space || (char_in >= mtsd_pkg::CHAR_TAB && char_in <= mtsd_pkg::CHAR_CR);
    assign is_dot   = (char_in == mtsd_pkg::SYM_DOT);
    assign is_dash  = (char_in == mtsd_pkg::SYM_DASH);

    // Letter walk, space run and end-of-message handling
    always_comb
    begin
        in_letter_next = in_letter_reg;
        broken_next    = broken_reg;
        pos_next       = pos_reg;
        run_next       = run_reg;
        whl_next       = whl_reg;
        finish         = 1'b0;
        add_pend       = 1'b0;
        fin_pos        = pos_reg;
        fin_broken     = broken_reg;

        if (accept && !is_write)
        begin
            if (is_ws)
            begin
                if (in_letter_reg)
                begin
                    finish         = 1'b1;
                    in_letter_next = 1'b0;
                    broken_next    = 1'b0;
                    pos_next       = 8'd1;
                end
            end
            else
            begin
                if (!in_letter_reg)
                begin
                    in_letter_next = 1'b1;
                    broken_next    = 1'b0;
                    pos_next       = 8'd1;
                    whl_next       = 1'b1;
                end
                if ((is_dot || is_dash) && !broken_next)
                begin
                    if (pos_next >= 8'(mtsd_pkg::POS_LIMIT))
                    begin
                        broken_next = 1'b1;
                    end
                    else
                    begin
                        pos_next = {pos_next[6:0], is_dash};
                    end
                end
            end

            // six spaces in a row close a word
            if (is_space)
            begin
                if (run_reg == mtsd_pkg::WORD_SPACES - 3'd1)
                begin
                    run_next = 3'd0;
                    if (whl_next)
                    begin
                        add_pend = 1'b1;
                    end
                    whl_next = 1'b0;
                end
                else
                begin
                    run_next = run_reg + 3'd1;
                end
            end
            else
            begin
                run_next = 3'd0;
            end

            if (end_of_message)
            begin
                if (in_letter_next)
                begin
                    finish     = 1'b1;
                    fin_pos    = pos_next;
                    fin_broken = broken_next;
                end
                if (whl_next)
                begin
                    add_pend = 1'b1;
                end
                in_letter_next = 1'b0;
                broken_next    = 1'b0;
                pos_next       = 8'd1;
                run_next       = 3'd0;
                whl_next       = 1'b0;
            end
        end
    end

    // Command build; requests with no effect on the back are not queued
    always_comb
    begin
        cmd.kind     = is_write ? mtsd_pkg::CMD_WRITE : mtsd_pkg::CMD_DECODE;
        cmd.addr     = is_write ? table_index : fin_pos;
        cmd.wdata    = table_value;
        cmd.finish   = finish;
        cmd.broken   = fin_broken;
        cmd.add_pend = add_pend;
        cmd.eom      = end_of_message;
        cmd_push     = accept && (is_write || finish || add_pend || end_of_message);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_letter_reg <= 1'b0;
            broken_reg    <= 1'b0;
            pos_reg       <= 8'd1;
            run_reg       <= 3'd0;
            whl_reg       <= 1'b0;
        end
        else
        begin
            in_letter_reg <= in_letter_next;
            broken_reg    <= broken_next;
            pos_reg       <= pos_next;
            run_reg       <= run_next;
            whl_reg       <= whl_next;
        end
    end

endmodule

// File: sv/mtsd_queue.sv
// Short command queue between front and back.
module mtsd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mtsd_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output mtsd_pkg::cmd_t head
);

    localparam int AW = $clog2(mtsd_pkg::QUEUE_DEPTH);

    mtsd_pkg::cmd_t entry_reg [mtsd_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [AW:0]    count_reg, count_next;

    assign full       = (count_reg == (AW+1)'(mtsd_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(mtsd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(mtsd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: sv/mtsd_back.sv
// Back end: tree table, pending spaces and result sequencing.
module mtsd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  mtsd_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_char,
    output logic           out_last
);

    // Tree table with per-entry valid bits (unwritten entries read as zero)
    logic [mtsd_pkg::TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic                             ram_we;
    logic                             ram_re;
    logic [mtsd_pkg::TABLE_WIDTH-1:0] ram_rdata;

    // Execute stage
    logic       ex_valid_reg, ex_valid_next;
    logic       fresh_reg, fresh_next;
    logic       hit_reg, hit_next;
    logic       ex_finish_reg, ex_finish_next;
    logic       ex_broken_reg, ex_broken_next;
    logic       ex_add_reg, ex_add_next;
    logic       ex_eom_reg, ex_eom_next;
    logic [3:0] rem_reg, rem_next;
    logic       char_reg, char_next;
    logic [3:0] pending_reg, pending_next;

    // Output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg, out_char_next;
    logic       out_last_reg, out_last_next;

    logic [7:0] ch;
    logic       letter_ok;
    logic [3:0] pend1;
    logic [3:0] pend2;
    logic [3:0] fresh_spaces;
    logic [3:0] cur_spaces;
    logic       cur_char;
    logic       has_result;
    logic       out_free;
    logic       emit;
    logic       emit_last;
    logic       ex_done;
    logic       pop_decode;
    logic       pop_write;

    mtsd_ram #(
        .WIDTH (mtsd_pkg::TABLE_WIDTH),
        .DEPTH (mtsd_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (cmd.addr),
        .wdata (cmd.wdata),
        .rdata (ram_rdata)
    );

    // Result counts for the command in the execute stage
    always_comb
    begin
        ch        = (hit_reg && !ex_broken_reg) ? ram_rdata : 8'd0;
        letter_ok = ex_finish_reg && (ch != 8'd0);
        pend1     = letter_ok ? 4'd0 : pending_reg;
        pend2     = (ex_add_reg && pend1 < 4'(mtsd_pkg::PENDING_CAP)) ? pend1 + 4'd1 : pend1;
        if (letter_ok)
        begin
            fresh_spaces = pending_reg;
        end
        else if (ex_eom_reg && pend2 != 4'd0)
        begin
            fresh_spaces = pend2 - 4'd1;
        end
        else
        begin
            fresh_spaces = 4'd0;
        end
        cur_spaces = fresh_reg ? fresh_spaces : rem_reg;
        cur_char   = fresh_reg ? letter_ok : char_reg;
        has_result = (cur_spaces != 4'd0) || cur_char;
        out_free   = !out_valid_reg || out_ready;
        emit       = ex_valid_reg && has_result && out_free;
        emit_last  = (cur_spaces == 4'd0) || (cur_spaces == 4'd1 && !cur_char);
        ex_done    = ex_valid_reg && (!has_result || (emit && emit_last));
    end

    // Command pop and table access
    assign cmd_pop    = cmd_valid && (!ex_valid_reg || ex_done);
    assign pop_decode = cmd_pop && (cmd.kind == mtsd_pkg::CMD_DECODE);
    assign pop_write  = cmd_pop && (cmd.kind == mtsd_pkg::CMD_WRITE);
    assign ram_we     = pop_write;
    assign ram_re     = pop_decode;

    // Execute stage and pending counter update
    always_comb
    begin
        valid_next     = valid_reg;
        ex_valid_next  = ex_valid_reg;
        fresh_next     = fresh_reg;
        hit_next       = hit_reg;
        ex_finish_next = ex_finish_reg;
        ex_broken_next = ex_broken_reg;
        ex_add_next    = ex_add_reg;
        ex_eom_next    = ex_eom_reg;
        rem_next       = rem_reg;
        char_next      = char_reg;
        pending_next   = pending_reg;

        if (ex_valid_reg)
        begin
            fresh_next = 1'b0;
            rem_next   = (emit && cur_spaces != 4'd0) ? cur_spaces - 4'd1 : cur_spaces;
            char_next  = (emit && cur_spaces == 4'd0) ? 1'b0 : cur_char;
            if (fresh_reg)
            begin
                pending_next = ex_eom_reg ? 4'd0 : pend2;
            end
            if (ex_done)
            begin
                ex_valid_next = 1'b0;
            end
        end

        if (pop_write)
        begin
            valid_next[cmd.addr] = 1'b1;
        end

        if (pop_decode)
        begin
            ex_valid_next  = 1'b1;
            fresh_next     = 1'b1;
            hit_next       = valid_reg[cmd.addr];
            ex_finish_next = cmd.finish;
            ex_broken_next = cmd.broken;
            ex_add_next    = cmd.add_pend;
            ex_eom_next    = cmd.eom;
        end
    end

    // Output register: spaces first, then the letter
    always_comb
    begin
        out_char_next = out_char_reg;
        out_last_next = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = (cur_spaces == 4'd0) ? ch : mtsd_pkg::SYM_SPACE;
            out_last_next  = emit_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            ex_valid_reg  <= 1'b0;
            fresh_reg     <= 1'b0;
            hit_reg       <= 1'b0;
            ex_finish_reg <= 1'b0;
            ex_broken_reg <= 1'b0;
            ex_add_reg    <= 1'b0;
            ex_eom_reg    <= 1'b0;
            rem_reg       <= 4'd0;
            char_reg      <= 1'b0;
            pending_reg   <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            ex_valid_reg  <= ex_valid_next;
            fresh_reg     <= fresh_next;
            hit_reg       <= hit_next;
            ex_finish_reg <= ex_finish_next;
            ex_broken_reg <= ex_broken_next;
            ex_add_reg    <= ex_add_next;
            ex_eom_reg    <= ex_eom_next;
            rem_reg       <= rem_next;
            char_reg      <= char_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule
